FILE: rtl/core/id_slot_table_assert.svh
// Assertion macros used by the id slot table RTL (included by ist_back).
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ID_SLOT_TABLE_ASSERT_SVH
`define ID_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// a implies b in the same cycle
`define IST_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("id_slot_table: assertion failed");

// a implies b in the next cycle
`define IST_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("id_slot_table: assertion failed");

`else

`define IST_ASSERT_IMP(label, clk, rst, a, b)
`define IST_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: rtl/core/ist_pkg.sv
// Shared types and constants for the id slot table.
// Used by every module in rtl/core; no dependencies.
package ist_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int ID_W       = 8;
  localparam int SLOT_IN_W  = 8;
  localparam int RES_SLOT_W = 3;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [ID_W-1:0]   ID_INVALID = '1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   node_id;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
  } item_t;

endpackage

FILE: rtl/core/ist_front.sv
// Front end: takes commands off the start/busy port and classifies them.
// Depends on ist_pkg.
module ist_front (
  input  logic                           start,
  input  logic [1:0]                     command,
  input  logic [ist_pkg::ID_W-1:0]       node_id,
  input  logic [ist_pkg::SLOT_IN_W-1:0]  slot,
  input  logic                           full,
  output logic                           busy,
  output logic                           push,
  output ist_pkg::item_t                 item
);
  import ist_pkg::*;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    item.cmd      = cmd_t'(command);
    item.node_id  = node_id;
    // range check done once here so the back end only sees a flag
    item.slot_ok  = {1'b0, slot} < (SLOT_IN_W + 1)'(NUM_SLOTS);
    item.slot_idx = SLOT_W'(slot);
  end

endmodule

FILE: rtl/core/ist_queue.sv
// Short command queue decoupling the front end from the scan engine.
// Depends on ist_pkg.
module ist_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ist_pkg::item_t wr_item,
  input  logic           pop,
  output ist_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import ist_pkg::*;

  item_t             fifo_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QDEPTH);
  assign empty   = count == '0;
  assign rd_item = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/ist_back.sv
// Back end: holds the ID table and scans it one slot per cycle.
// Depends on ist_pkg and id_slot_table_assert.svh.
module ist_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  ist_pkg::item_t                   q_item,
  output logic                             pop,
  output logic                             done,
  output logic                             ok,
  output logic [ist_pkg::RES_SLOT_W-1:0]   slot_result,
  output logic [ist_pkg::ID_W-1:0]         id_result
);
  import ist_pkg::*;
  `include "id_slot_table_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } state_t;

  state_t               state;
  item_t                cur_item;
  logic [SLOT_W-1:0]    cur;
  logic [ID_W-1:0]      mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld;
  logic [ID_W-1:0]      rd_raw;
  logic                 rd_vld;
  logic [SLOT_W-1:0]    rd_addr;
  logic [ID_W-1:0]      entry;
  logic                 is_empty;
  logic                 hit;
  logic                 mem_we;

  assign pop = (state == S_IDLE) && !q_empty;

  // read address runs one slot ahead of the entry being compared
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = (q_item.cmd == CMD_READ && q_item.slot_ok) ? q_item.slot_idx : '0;
    end else if (cur == LAST_SLOT) begin
      rd_addr = cur;
    end else begin
      rd_addr = cur + 1'b1;
    end
  end

  // a slot never written since reset or clear reads as empty
  assign entry    = rd_vld ? rd_raw : '0;
  assign is_empty = entry == '0;
  assign hit      = (cur_item.cmd == CMD_ADD) ? (is_empty || entry == cur_item.node_id)
                                              : (entry == cur_item.node_id);
  assign mem_we   = (state == S_SCAN) && (cur_item.cmd == CMD_ADD) && is_empty;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur] <= cur_item.node_id;
    end
    rd_raw <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur_item <= q_item;
            cur      <= '0;
            case (q_item.cmd)
              CMD_CLEAR: begin
                vld         <= '0;
                done        <= 1'b1;
                ok          <= 1'b1;
                slot_result <= '0;
                id_result   <= '0;
              end
              CMD_READ: state <= S_READ;
              default:  state <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          if (mem_we) begin
            vld[cur] <= 1'b1;
          end
          if (hit) begin
            done        <= 1'b1;
            ok          <= 1'b1;
            slot_result <= RES_SLOT_W'(cur);
            id_result   <= '0;
            state       <= S_IDLE;
          end else if (cur == LAST_SLOT) begin
            done        <= 1'b1;
            ok          <= 1'b0;
            slot_result <= '0;
            id_result   <= '0;
            state       <= S_IDLE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_READ: begin
          done        <= 1'b1;
          slot_result <= '0;
          state       <= S_IDLE;
          if (cur_item.slot_ok) begin
            ok        <= 1'b1;
            id_result <= entry;
          end else begin
            ok        <= 1'b0;
            id_result <= ID_INVALID;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IST_ASSERT_IMP(a_scan_in_range, clk, rst, state == S_SCAN, cur <= LAST_SLOT)
  `IST_ASSERT_IMP(a_fail_no_slot, clk, rst, done && !ok, slot_result == '0)
  `IST_ASSERT_IMP(a_one_field, clk, rst, done, slot_result == '0 || id_result == '0)
  `IST_ASSERT_NEXT(a_write_ends_scan, clk, rst, mem_we, state == S_IDLE && done && ok)

endmodule

FILE: rtl/core/id_slot_table.sv
// Top level of the id slot table: front end, command queue, scan engine.
// Depends on ist_pkg, ist_front, ist_queue and ist_back.
//
// A command is taken when start is high and busy is low. It enters a
// two-deep queue, so busy only rises when two commands are waiting behind
// the one in progress. The scan engine reads the table through a single
// registered read port, one slot per cycle. Add and find scan from slot 0 up
// to the first hit; read fetches one slot; clear completes from idle.
// Each result appears on ok, slot_result and id_result for exactly one
// cycle with done high; there is no way to hold it off, so the receiver
// must take it in that cycle. The table comes out of reset empty.
module id_slot_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       command,
  input  logic [ist_pkg::ID_W-1:0]         node_id,
  input  logic [ist_pkg::SLOT_IN_W-1:0]    slot,
  output logic                             busy,
  output logic                             done,
  output logic                             ok,
  output logic [ist_pkg::RES_SLOT_W-1:0]   slot_result,
  output logic [ist_pkg::ID_W-1:0]         id_result
);
  import ist_pkg::*;

  item_t push_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  ist_front u_front (
    .start   (start),
    .command (command),
    .node_id (node_id),
    .slot    (slot),
    .full    (q_full),
    .busy    (busy),
    .push    (push),
    .item    (push_item)
  );

  ist_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  ist_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_item      (q_item),
    .pop         (pop),
    .done        (done),
    .ok          (ok),
    .slot_result (slot_result),
    .id_result   (id_result)
  );

endmodule

FILE: dv/id_slot_table_tb.sv
// Self-checking testbench for id_slot_table: directed and random command items.
// Depends on ist_pkg and the id_slot_table RTL; expected results come from an
// in-bench model of the slot table kept in a small scoreboard class.
module id_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ist_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 725;
  localparam int POOL_SIZE  = 12;

  typedef struct packed {
    logic                  ok;
    logic [RES_SLOT_W-1:0] slot_res;
    logic [ID_W-1:0]       id_res;
  } table_result_t;

  class slot_table_scoreboard;
    logic [ID_W-1:0] id_store [NUM_SLOTS];
    table_result_t   expected_q [$];
    int              mismatches;
    int              n_items;
    int              n_results;
    int              n_refused;
    int              n_clears;

    function new();
      foreach (id_store[i]) id_store[i] = '0;
      mismatches = 0;
      n_items    = 0;
      n_results  = 0;
      n_refused  = 0;
      n_clears   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // update the table copy and queue the expected outcome of one item
    function void note_item(cmd_t cmd, logic [ID_W-1:0] id, logic [SLOT_IN_W-1:0] where);
      table_result_t r;
      bit            hit;
      r   = '0;
      hit = 1'b0;
      case (cmd)
        CMD_ADD: begin
          // stop at the first empty slot or the first match, whichever comes first
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && (id_store[i] == '0 || id_store[i] == id)) begin
              id_store[i] = id;
              r.ok        = 1'b1;
              r.slot_res  = RES_SLOT_W'(i);
              hit         = 1'b1;
            end
          end
        end
        CMD_FIND: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && id_store[i] == id) begin
              r.ok       = 1'b1;
              r.slot_res = RES_SLOT_W'(i);
              hit        = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (where < NUM_SLOTS) begin
            r.ok     = 1'b1;
            r.id_res = id_store[where];
          end else begin
            r.id_res = ID_INVALID;
          end
        end
        default: begin
          foreach (id_store[i]) id_store[i] = '0;
          r.ok = 1'b1;
          n_clears++;
        end
      endcase
      if (!r.ok) n_refused++;
      n_items++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic ok, logic [RES_SLOT_W-1:0] slot_res, logic [ID_W-1:0] id_res);
      table_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: ok=%0b slot=%0d id=%0h",
                   $realtime, ok, slot_res, id_res);
        return;
      end
      want = expected_q.pop_front();
      if (ok !== want.ok || slot_res !== want.slot_res || id_res !== want.id_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected ok=%0b slot=%0d id=%0h, got ok=%0b slot=%0d id=%0h",
                   $realtime, want.ok, want.slot_res, want.id_res, ok, slot_res, id_res);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [1:0]            command = CMD_ADD;
  logic [ID_W-1:0]       node_id = '0;
  logic [SLOT_IN_W-1:0]  slot = '0;
  logic                  busy;
  logic                  done;
  logic                  ok;
  logic [RES_SLOT_W-1:0] slot_result;
  logic [ID_W-1:0]       id_result;

  slot_table_scoreboard sb = new();
  int                   idle_cycles = 0;
  logic [ID_W-1:0]      id_pool [POOL_SIZE];

  always #6 clk = ~clk;

  id_slot_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .node_id     (node_id),
    .slot        (slot),
    .busy        (busy),
    .done        (done),
    .ok          (ok),
    .slot_result (slot_result),
    .id_result   (id_result)
  );

  // item and result monitor; everything is sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(cmd_t'(command), node_id, slot);
      if (done) sb.check_result(ok, slot_result, id_result);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input cmd_t c, input logic [ID_W-1:0] id,
                           input logic [SLOT_IN_W-1:0] where, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    node_id <= id;
    slot    <= where;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int            pick;
    int            gap;
    cmd_t          c;
    logic [ID_W-1:0]      id;
    logic [SLOT_IN_W-1:0] where;

    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(1, 255));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table: ID zero matches slot 0, misses, reads in and out of range
    send_item(CMD_FIND,  8'h00, 8'd0,   0);
    send_item(CMD_ADD,   8'h00, 8'd0,   0);
    send_item(CMD_FIND,  8'h5A, 8'd0,   0);
    send_item(CMD_READ,  8'h00, 8'd0,   0);
    send_item(CMD_READ,  8'h00, 8'd8,   0);
    send_item(CMD_READ,  8'hFF, 8'd255, 0);
    // fill every slot
    send_item(CMD_ADD,   8'hFF, 8'd0,   0);
    send_item(CMD_ADD,   8'h01, 8'd0,   0);
    send_item(CMD_ADD,   8'h80, 8'd0,   0);
    send_item(CMD_ADD,   8'h55, 8'd0,   0);
    send_item(CMD_ADD,   8'hAA, 8'd0,   0);
    send_item(CMD_ADD,   8'h7F, 8'd0,   0);
    send_item(CMD_ADD,   8'h10, 8'd0,   0);
    send_item(CMD_ADD,   8'h02, 8'd0,   0);
    // full table: new ID refused, existing ID found, zero has no empty slot
    send_item(CMD_ADD,   8'h33, 8'd0,   0);
    send_item(CMD_ADD,   8'h55, 8'd0,   0);
    send_item(CMD_FIND,  8'h02, 8'd0,   0);
    send_item(CMD_FIND,  8'h00, 8'd0,   0);
    send_item(CMD_ADD,   8'h00, 8'd0,   0);
    send_item(CMD_READ,  8'h00, 8'd7,   0);
    send_item(CMD_CLEAR, 8'h00, 8'd0,   0);
    send_item(CMD_FIND,  8'hFF, 8'd0,   0);
    send_item(CMD_ADD,   8'hC3, 8'd0,   0);
    send_item(CMD_READ,  8'h00, 8'd0,   0);

    for (int n = 0; n < N_RANDOM; n++) begin
      // mostly adds, finds and reads from a small ID pool so the table fills
      // and hits are common; an occasional clear starts a new fill
      pick = $urandom_range(0, 99);
      if (pick < 45)      c = CMD_ADD;
      else if (pick < 70) c = CMD_FIND;
      else if (pick < 96) c = CMD_READ;
      else                c = CMD_CLEAR;

      pick = $urandom_range(0, 99);
      if (pick < 60)      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 65) id = '0;
      else                id = ID_W'($urandom_range(0, 255));

      if ($urandom_range(0, 3) != 0) where = SLOT_IN_W'($urandom_range(0, NUM_SLOTS - 1));
      else                           where = SLOT_IN_W'($urandom_range(0, 255));

      gap = 0;
      if (n < N_RANDOM - 150 && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);

      if (n == 300) drain_results();
      send_item(c, id, where, gap);
    end

    drain_results();
    repeat (30) @(posedge clk);

    $display("Ran %0d commands (%0d clears); %0d results compared, %0d of them refusals.",
             sb.n_items, sb.n_clears, sb.n_results, sb.n_refused);
    $display("Mismatches: %0d, results still outstanding: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ist_pkg.sv
rtl/core/ist_front.sv
rtl/core/ist_queue.sv
rtl/core/ist_back.sv
rtl/core/id_slot_table.sv
dv/id_slot_table_tb.sv
